/* rtl/core/recursive_lock_unit_assert.svh */
// Assertion macros for the recursive lock unit.
`ifndef RECURSIVE_LOCK_UNIT_ASSERT_SVH
`define RECURSIVE_LOCK_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define RLU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("recursive lock unit check failed");

// Check a consequent in the cycle after its antecedent.
`define RLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("recursive lock unit check failed");

`endif

/* rtl/core/rlu_pkg.sv */
// Package with types and defaults of the recursive lock unit.
package rlu_pkg;

  localparam int unsigned WaiterDepthDefault  = 16;
  localparam int unsigned ThreadIdBitsDefault = 8;
  localparam int unsigned CountBitsDefault    = 16;

  localparam int unsigned TidPortBits   = 8;
  localparam int unsigned DepthPortBits = 16;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ACQUIRED   = 3'd0,
    ST_WAIT       = 3'd1,
    ST_REL_HELD   = 3'd2,
    ST_REL_FREE   = 3'd3,
    ST_REL_ERR    = 3'd4,
    ST_STACK_FULL = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_t;

endpackage

/* rtl/core/recursive_lock_unit.sv */
// Recursive lock with hold count and last-in-first-out waiter stack.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------------
//   in      | in_valid  | in_stall  | opcode, thread_id
//   out     | out_valid | out_stall | status, woken_valid, woken_thread, hold_depth
//
// One request per cycle while in_stall is low.
// Each request passes an input register, one step of lock and stack logic, and a
// result register; the stack top and the entry below it are held in flip-flops and
// the next entry down is read ahead from the stack memory.
// Reset clears the lock, the stack pointer and both pipeline registers; no clearing pass.
// in_stall rises only while the input register and the result register are both full
// and out_stall is high.
`include "recursive_lock_unit_assert.svh"

module recursive_lock_unit #(
  parameter int unsigned WAITER_DEPTH   = rlu_pkg::WaiterDepthDefault,
  parameter int unsigned THREAD_ID_BITS = rlu_pkg::ThreadIdBitsDefault,
  parameter int unsigned COUNT_BITS     = rlu_pkg::CountBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rlu_pkg::opcode_t                    opcode,
  input  logic [rlu_pkg::TidPortBits-1:0]     thread_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rlu_pkg::status_t                    status,
  output logic                                woken_valid,
  output logic [rlu_pkg::TidPortBits-1:0]     woken_thread,
  output logic [rlu_pkg::DepthPortBits-1:0]   hold_depth
);
  import rlu_pkg::*;

  localparam int unsigned CW = $clog2(WAITER_DEPTH + 1);
  localparam int unsigned AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;

  logic                      req_full;
  opcode_t                   req_op;
  logic [THREAD_ID_BITS-1:0] req_tid;

  logic [THREAD_ID_BITS-1:0] owner_id;
  logic [COUNT_BITS-1:0]     hold_count;
  logic [CW-1:0]             waiter_top;
  logic [THREAD_ID_BITS-1:0] top_entry;
  logic [THREAD_ID_BITS-1:0] below_entry;
  logic [THREAD_ID_BITS-1:0] waiter_stack [WAITER_DEPTH];

  logic                      advance;
  logic                      accept;
  logic [31:0]               tid_wide;
  logic [31:0]               woken_wide;
  logic [31:0]               count_wide;

  logic [THREAD_ID_BITS-1:0] owner_id_next;
  logic [COUNT_BITS-1:0]     hold_count_next;
  status_t                   status_next;
  logic                      woken_valid_next;
  logic [THREAD_ID_BITS-1:0] woken_next;
  logic                      push;
  logic                      pop;
  logic [CW-1:0]             read_ptr;

  assign advance  = req_full && (!out_valid || !out_stall);
  assign in_stall = req_full && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tid_wide = 32'(thread_id);
  assign read_ptr = waiter_top - CW'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else begin
      req_full <= accept || (req_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= opcode;
      req_tid <= tid_wide[THREAD_ID_BITS-1:0];
    end
  end

  always_comb begin
    owner_id_next    = owner_id;
    hold_count_next  = hold_count;
    status_next      = ST_REL_ERR;
    woken_valid_next = 1'b0;
    woken_next       = '0;
    push             = 1'b0;
    pop              = 1'b0;
    unique case (req_op)
      OP_ACQUIRE: begin
        if (hold_count == '0) begin
          owner_id_next   = req_tid;
          hold_count_next = COUNT_BITS'(1);
          status_next     = ST_ACQUIRED;
        end else if (owner_id == req_tid) begin
          if (&hold_count) begin
            status_next = ST_OVERFLOW;
          end else begin
            hold_count_next = hold_count + COUNT_BITS'(1);
            status_next     = ST_ACQUIRED;
          end
        end else if (waiter_top == CW'(WAITER_DEPTH)) begin
          status_next = ST_STACK_FULL;
        end else begin
          push        = 1'b1;
          status_next = ST_WAIT;
        end
      end
      OP_RELEASE: begin
        if (hold_count == '0 || owner_id != req_tid) begin
          status_next = ST_REL_ERR;
        end else begin
          hold_count_next = hold_count - COUNT_BITS'(1);
          if (hold_count != COUNT_BITS'(1)) begin
            status_next = ST_REL_HELD;
          end else begin
            status_next   = ST_REL_FREE;
            owner_id_next = '0;
            if (waiter_top != '0) begin
              pop              = 1'b1;
              woken_valid_next = 1'b1;
              woken_next       = top_entry;
            end
          end
        end
      end
    endcase
  end

  assign woken_wide = 32'(woken_next);
  assign count_wide = 32'(hold_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_id   <= '0;
      hold_count <= '0;
      waiter_top <= '0;
    end else if (advance) begin
      owner_id   <= owner_id_next;
      hold_count <= hold_count_next;
      if (push) begin
        waiter_top <= waiter_top + CW'(1);
      end else if (pop) begin
        waiter_top <= waiter_top - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      waiter_stack[waiter_top[AW-1:0]] <= req_tid;
      top_entry                        <= req_tid;
      below_entry                      <= top_entry;
    end else if (advance && pop) begin
      top_entry   <= below_entry;
      below_entry <= waiter_stack[read_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= status_next;
      woken_valid  <= woken_valid_next;
      woken_thread <= woken_wide[TidPortBits-1:0];
      hold_depth   <= count_wide[DepthPortBits-1:0];
    end
  end

  `RLU_ASSERT_SAME(a_top_in_range, clk, rst, 1'b1, waiter_top <= CW'(WAITER_DEPTH))
  `RLU_ASSERT_SAME(a_free_no_owner, clk, rst, hold_count == '0, owner_id == '0)
  `RLU_ASSERT_SAME(a_wake_on_free, clk, rst, out_valid && woken_valid,
                   status == ST_REL_FREE && hold_depth == '0)
  `RLU_ASSERT_NEXT(a_pop_moves_top, clk, rst, advance && pop,
                   waiter_top == $past(waiter_top) - CW'(1))
  `RLU_ASSERT_NEXT(a_push_keeps_entry, clk, rst, advance && push,
                   top_entry == $past(req_tid))

endmodule

/* tb/recursive_lock_unit_tb.sv */
// Testbench of the recursive lock unit: directed table plus random requests, scoreboarded.
module recursive_lock_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlu_pkg::*;

  localparam int unsigned WAITER_SLOTS    = WaiterDepthDefault;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam int unsigned RANDOM_REQUESTS = 1050;
  localparam int unsigned STEADY_TAIL     = 150;
  localparam int unsigned POOL_SIZE       = 6;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DIRECTED_ROWS   = 15;

  typedef struct packed {
    status_t     status;
    logic        woken_valid;
    logic [7:0]  woken_thread;
    logic [15:0] hold_depth;
  } lock_result_t;

  typedef struct {
    opcode_t      op;
    logic [7:0]   tid;
    int unsigned  reps;
    bit           fixed;
    lock_result_t result;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  opcode_t     opcode = OP_ACQUIRE;
  logic [7:0]  thread_id = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     status;
  logic        woken_valid;
  logic [7:0]  woken_thread;
  logic [15:0] hold_depth;

  logic [7:0]  lock_owner = 8'h00;
  logic [15:0] lock_count = 16'h0000;
  logic [7:0]  waiters [WAITER_SLOTS];
  int unsigned waiter_count = 0;
  bit          wake_pending = 1'b0;
  logic [7:0]  wake_id = 8'h00;

  lock_result_t    expected_results [$];
  int unsigned     fail_count = 0;
  longint unsigned cycle_count = 0;
  bit              steady = 1'b0;
  int unsigned     stall_left = 0;

  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_RELEASE, 8'h00, 1,     1'b1, '{ST_REL_ERR,    1'b0, 8'h00, 16'd0}},
    '{OP_ACQUIRE, 8'hFF, 1,     1'b1, '{ST_ACQUIRED,   1'b0, 8'h00, 16'd1}},
    '{OP_RELEASE, 8'hFF, 1,     1'b1, '{ST_REL_FREE,   1'b0, 8'h00, 16'd0}},
    '{OP_ACQUIRE, 8'hFF, 1,     1'b1, '{ST_ACQUIRED,   1'b0, 8'h00, 16'd1}},
    '{OP_RELEASE, 8'h00, 1,     1'b1, '{ST_REL_ERR,    1'b0, 8'h00, 16'd1}},
    '{OP_ACQUIRE, 8'h00, 1,     1'b1, '{ST_WAIT,       1'b0, 8'h00, 16'd1}},
    '{OP_ACQUIRE, 8'h5A, 14,    1'b0, '0},
    '{OP_ACQUIRE, 8'hA5, 1,     1'b1, '{ST_WAIT,       1'b0, 8'h00, 16'd1}},
    '{OP_ACQUIRE, 8'h33, 1,     1'b1, '{ST_STACK_FULL, 1'b0, 8'h00, 16'd1}},
    '{OP_RELEASE, 8'h80, 1,     1'b1, '{ST_REL_ERR,    1'b0, 8'h00, 16'd1}},
    '{OP_RELEASE, 8'hFF, 1,     1'b1, '{ST_REL_FREE,   1'b1, 8'hA5, 16'd0}},
    '{OP_RELEASE, 8'hFF, 1,     1'b1, '{ST_REL_ERR,    1'b0, 8'h00, 16'd0}},
    '{OP_ACQUIRE, 8'hA5, 1,     1'b1, '{ST_ACQUIRED,   1'b0, 8'h00, 16'd1}},
    '{OP_ACQUIRE, 8'h01, 1,     1'b1, '{ST_WAIT,       1'b0, 8'h00, 16'd1}},
    '{OP_RELEASE, 8'hA5, 1,     1'b1, '{ST_REL_FREE,   1'b1, 8'h01, 16'd0}}
  };

  recursive_lock_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .thread_id    (thread_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread),
    .hold_depth   (hold_depth)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic lock_result_t advance_lock(opcode_t op, logic [7:0] tid);
    lock_result_t r;
    r = '0;
    if (op == OP_ACQUIRE) begin
      if (lock_count == 16'd0) begin
        lock_owner = tid;
        lock_count = 16'd1;
        r.status = ST_ACQUIRED;
      end else if (lock_owner == tid) begin
        if (lock_count == COUNT_MAX) begin
          r.status = ST_OVERFLOW;
        end else begin
          lock_count = lock_count + 16'd1;
          r.status = ST_ACQUIRED;
        end
      end else if (waiter_count >= WAITER_SLOTS) begin
        r.status = ST_STACK_FULL;
      end else begin
        waiters[waiter_count] = tid;
        waiter_count++;
        r.status = ST_WAIT;
      end
    end else if (lock_count == 16'd0 || lock_owner != tid) begin
      r.status = ST_REL_ERR;
    end else begin
      lock_count = lock_count - 16'd1;
      if (lock_count != 16'd0) begin
        r.status = ST_REL_HELD;
      end else begin
        r.status = ST_REL_FREE;
        lock_owner = 8'h00;
        if (waiter_count > 0) begin
          waiter_count--;
          r.woken_valid = 1'b1;
          r.woken_thread = waiters[waiter_count];
          wake_pending = 1'b1;
          wake_id = waiters[waiter_count];
        end
      end
    end
    r.hold_depth = lock_count;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    fail_count++;
    if (fail_count <= 50) begin
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  task automatic issue_request(opcode_t op, logic [7:0] tid, bit fixed, lock_result_t result);
    lock_result_t predicted;
    opcode    <= op;
    thread_id <= tid;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = advance_lock(op, tid);
    expected_results.push_back(fixed ? result : predicted);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (!steady && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    lock_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", {13'd0, status}, 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", {13'd0, status}, {13'd0, want.status});
        end
        if (woken_valid !== want.woken_valid) begin
          report_mismatch("woken_valid", {15'd0, woken_valid}, {15'd0, want.woken_valid});
        end
        if (woken_thread !== want.woken_thread) begin
          report_mismatch("woken_thread", {8'd0, woken_thread}, {8'd0, want.woken_thread});
        end
        if (hold_depth !== want.hold_depth) begin
          report_mismatch("hold_depth", hold_depth, want.hold_depth);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [7:0]  thread_pool [POOL_SIZE];
    logic [7:0]  tid;
    logic [7:0]  pick;
    opcode_t     op;
    int unsigned roll;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        issue_request(directed_rows[i].op, directed_rows[i].tid,
                      directed_rows[i].fixed, directed_rows[i].result);
      end
    end

    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) begin
        drain_results();
      end
      if (n == RANDOM_REQUESTS - STEADY_TAIL) begin
        steady = 1'b1;
      end
      if (n % 150 == 0) begin
        foreach (thread_pool[k]) thread_pool[k] = 8'($urandom_range(0, 255));
      end
      roll = $urandom_range(0, 99);
      pick = thread_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 8) begin
        op  = opcode_t'($urandom_range(0, 1));
        tid = 8'($urandom_range(0, 255));
      end else if (lock_count == 16'd0) begin
        op = OP_ACQUIRE;
        if (wake_pending) begin
          tid = wake_id;
          wake_pending = 1'b0;
        end else begin
          tid = pick;
        end
      end else if (roll < 40) begin
        op  = OP_RELEASE;
        tid = lock_owner;
      end else if (roll < 55) begin
        op  = OP_ACQUIRE;
        tid = lock_owner;
      end else if (roll < 88) begin
        op  = OP_ACQUIRE;
        tid = pick;
      end else begin
        op  = OP_RELEASE;
        tid = pick;
      end
      issue_request(op, tid, 1'b0, '0);
    end

    drain_results();
    repeat (6) @(posedge clk);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
